>>> design/bsab_pkg.sv
// Shared types, constants and channel arithmetic for the bilinear sprite blend.
// There are no dependencies. The filter stage and the top level both use this package.
`timescale 1ns / 1ps

package bsab_pkg;

    localparam int ChBits   = 8;
    localparam int NumCh    = 4;
    localparam int NumTaps  = 4;
    localparam int CfgIdxW  = 2;

    localparam logic [ChBits-1:0] ChMax = 8'd255;

    // Register indexes of the configuration port.
    localparam logic [CfgIdxW-1:0] RegFracX = 2'd0;
    localparam logic [CfgIdxW-1:0] RegFracY = 2'd1;

    // An ARGB pixel. Index 3 is alpha, then R, G and B.
    typedef logic [NumCh-1:0][ChBits-1:0] t_px;
    typedef logic [ChBits-1:0]            t_ch;

    // Scale one channel by w/256.
    function automatic t_ch scale_ch(input t_ch ch, input t_ch w);
        logic [2*ChBits-1:0] prod;
        prod = ch * w;
        return prod[2*ChBits-1:ChBits];
    endfunction

    // Add two channels and clamp at full scale.
    function automatic t_ch sat_add(input t_ch a, input t_ch b);
        logic [ChBits:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[ChBits] ? ChMax : sum[ChBits-1:0];
    endfunction

endpackage

>>> design/bilinear_sprite_alpha_blend_top.sv
// Top level: it holds the configuration registers, weight set-up, alpha blend and output stage.
// It depends on bsab_pkg and bsab_filter.
// A result reaches the ports once its request has passed the input register, the two filter stages,
// the blend-product register and the output register, with o_valid high for one cycle.
// Throughput: one request per cycle. The five-stage pipeline never stalls, and busy stays low.
// Reset (synchronous, active low) clears the fractions to zero and empties the pipeline.
// The receiver cannot stall. Each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module bilinear_sprite_alpha_blend_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [31:0]                  i_tap_here,
    input  logic [31:0]                  i_tap_right,
    input  logic [31:0]                  i_tap_below,
    input  logic [31:0]                  i_tap_below_right,
    input  logic [31:0]                  i_background,
    output logic                         o_valid,
    output logic [31:0]                  o_blended,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [bsab_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [7:0]                   i_cfg_data
);
    import bsab_pkg::*;

    t_ch                 r_frac_x;
    t_ch                 r_frac_y;
    t_ch [NumTaps-1:0]   n_weights;
    logic                r_valid_in;
    t_px [NumTaps-1:0]   r_taps;
    t_ch [NumTaps-1:0]   r_weights;
    t_px                 r_bg_in;
    logic                f_valid;
    t_px                 f_pix;
    t_px                 f_bg;
    logic                r_valid_b;
    t_px                 r_fg_part;
    t_px                 r_bg_part;
    logic                r_out_valid;
    t_px                 r_out;
    t_ch                 alpha;
    t_ch                 alpha_inv;
    t_px                 n_fg_part;
    t_px                 n_bg_part;
    t_px                 n_out;
    logic                accept;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    // Configuration registers. A write to any other index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac_x <= '0;
            r_frac_y <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                RegFracX: r_frac_x <= i_cfg_data;
                RegFracY: r_frac_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Tap weights from the fractions, one per tap in port order.
    always_comb begin
        n_weights[0] = scale_ch(r_frac_x, r_frac_y);
        n_weights[1] = scale_ch(ChMax - r_frac_x, r_frac_y);
        n_weights[2] = scale_ch(r_frac_x, ChMax - r_frac_y);
        n_weights[3] = scale_ch(ChMax - r_frac_x, ChMax - r_frac_y);
    end

    // Input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_in <= 1'b0;
        end else begin
            r_valid_in <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_taps[0] <= i_tap_here;
        r_taps[1] <= i_tap_right;
        r_taps[2] <= i_tap_below;
        r_taps[3] <= i_tap_below_right;
        r_weights <= n_weights;
        r_bg_in   <= i_background;
    end

    bsab_filter u_filter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_valid_in),
        .i_taps    (r_taps),
        .i_weights (r_weights),
        .i_bg      (r_bg_in),
        .o_valid   (f_valid),
        .o_pix     (f_pix),
        .o_bg      (f_bg)
    );

    // Blend products. Filtered alpha weighs the sprite, and its complement weighs the background.
    assign alpha     = f_pix[NumCh-1];
    assign alpha_inv = ChMax - alpha;

    always_comb begin
        for (int c = 0; c < NumCh; c++) begin
            n_fg_part[c] = scale_ch(f_pix[c], alpha);
            n_bg_part[c] = scale_ch(f_bg[c], alpha_inv);
        end
    end

    // Final channel sums.
    always_comb begin
        for (int c = 0; c < NumCh; c++) begin
            n_out[c] = sat_add(r_fg_part[c], r_bg_part[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_b   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_valid_b   <= f_valid;
            r_out_valid <= r_valid_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fg_part <= n_fg_part;
        r_bg_part <= n_bg_part;
        r_out     <= n_out;
    end

    assign o_valid   = r_out_valid;
    assign o_blended = r_out;

    // Every accepted request yields a result on o_valid.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##5 o_valid)
        else $error("result missing five cycles after request");

    // No result appears without a matching earlier request.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |-> ##5 !o_valid)
        else $error("result without a matching request");

    // The weights sum below full scale, so filtered alpha never saturates.
    a_alpha_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_valid |-> (f_pix[NumCh-1] != ChMax))
        else $error("filtered alpha reached full scale");

    // A blended channel stays below full scale.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_blended[31:24] != 8'hFF) && (o_blended[23:16] != 8'hFF)
                 && (o_blended[15:8] != 8'hFF) && (o_blended[7:0] != 8'hFF))
        else $error("blended channel reached full scale");

endmodule

>>> design/bsab_filter.sv
// Bilinear filter stages: four weighted taps per channel, then the summing tree.
// It depends on bsab_pkg. The background pixel travels alongside the taps.
`timescale 1ns / 1ps

module bsab_filter (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  bsab_pkg::t_px [bsab_pkg::NumTaps-1:0]  i_taps,
    input  bsab_pkg::t_ch [bsab_pkg::NumTaps-1:0]  i_weights,
    input  bsab_pkg::t_px                          i_bg,
    output logic                                   o_valid,
    output bsab_pkg::t_px                          o_pix,
    output bsab_pkg::t_px                          o_bg
);
    import bsab_pkg::*;

    logic                      r_valid_m;
    t_px [NumTaps-1:0]         r_scaled;
    t_px                       r_bg_m;
    logic                      r_valid_s;
    t_px                       r_pix;
    t_px                       r_bg_s;
    t_px [NumTaps-1:0]         n_scaled;
    t_px                       n_pix;

    // Each tap's channels are scaled by that tap's weight.
    always_comb begin
        for (int t = 0; t < NumTaps; t++) begin
            for (int c = 0; c < NumCh; c++) begin
                n_scaled[t][c] = scale_ch(i_taps[t][c], i_weights[t]);
            end
        end
    end

    // Pairwise clamped sums, in the same grouping as the blend equation.
    always_comb begin
        for (int c = 0; c < NumCh; c++) begin
            n_pix[c] = sat_add(sat_add(r_scaled[0][c], r_scaled[1][c]),
                               sat_add(r_scaled[2][c], r_scaled[3][c]));
        end
    end

    // Valid bits of the two stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_m <= 1'b0;
            r_valid_s <= 1'b0;
        end else begin
            r_valid_m <= i_valid;
            r_valid_s <= r_valid_m;
        end
    end

    // Payload registers of the two stages.
    always_ff @(posedge i_clk) begin
        r_scaled <= n_scaled;
        r_bg_m   <= i_bg;
        r_pix    <= n_pix;
        r_bg_s   <= r_bg_m;
    end

    assign o_valid = r_valid_s;
    assign o_pix   = r_pix;
    assign o_bg    = r_bg_s;

endmodule

>>> bench/blend_checker.sv
// Scoreboard for the bilinear sprite blend: it watches the request, result and register ports.
// It predicts each blended pixel from its own copy of the fractions and compares in order.
// It depends on bsab_pkg for the pixel types and register indexes.
`timescale 1ns / 1ps

module blend_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_busy,
    input  logic [31:0]                  i_tap_here,
    input  logic [31:0]                  i_tap_right,
    input  logic [31:0]                  i_tap_below,
    input  logic [31:0]                  i_tap_below_right,
    input  logic [31:0]                  i_background,
    input  logic                         i_valid,
    input  logic [31:0]                  i_blended,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [bsab_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [7:0]                   i_cfg_data,
    output int                           o_fail_count,
    output int                           o_pending
);
    import bsab_pkg::*;

    localparam int MaxReports = 10;

    t_ch frac_x_copy;
    t_ch frac_y_copy;
    t_px pixels_due[$];
    int  mismatches;
    int  pending_count;
    int  results_seen;

    assign o_fail_count = mismatches;
    assign o_pending    = pending_count;

    // Channel times weight over 256, the basic step of both filter and blend.
    function automatic t_ch weigh(input t_ch ch, input t_ch w);
        logic [15:0] prod;
        prod = {8'd0, ch} * {8'd0, w};
        return prod[15:8];
    endfunction

    // Clamp a channel sum at full scale.
    function automatic t_ch clamp_ch(input logic [9:0] sum);
        return (sum > 10'd255) ? ChMax : sum[7:0];
    endfunction

    // Bilinear filter of the four texels followed by the alpha blend onto the background.
    function automatic t_px blend_pixel(input t_px here, input t_px right, input t_px below,
                                        input t_px below_right, input t_px bg,
                                        input t_ch fx, input t_ch fy);
        t_ch        wt [NumTaps];
        t_px        texel [NumTaps];
        t_px        filtered;
        t_px        mixed;
        t_ch        alpha;
        logic [9:0] acc;
        wt[0] = weigh(fx, fy);
        wt[1] = weigh(ChMax - fx, fy);
        wt[2] = weigh(fx, ChMax - fy);
        wt[3] = weigh(ChMax - fx, ChMax - fy);
        texel[0] = here;
        texel[1] = right;
        texel[2] = below;
        texel[3] = below_right;
        for (int c = 0; c < NumCh; c++) begin
            acc = '0;
            for (int t = 0; t < NumTaps; t++) begin
                acc = acc + weigh(texel[t][c], wt[t]);
            end
            filtered[c] = clamp_ch(acc);
        end
        alpha = filtered[NumCh-1];
        for (int c = 0; c < NumCh; c++) begin
            acc = {2'b00, weigh(filtered[c], alpha)} + {2'b00, weigh(bg[c], ChMax - alpha)};
            mixed[c] = clamp_ch(acc);
        end
        return mixed;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MaxReports) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    initial begin
        frac_x_copy   = '0;
        frac_y_copy   = '0;
        mismatches    = 0;
        pending_count = 0;
        results_seen  = 0;
    end

    // Follow register writes, predict on each accepted request, check each result.
    always @(posedge i_clk) begin
        t_px want;
        if (!i_rst_n) begin
            frac_x_copy = '0;
            frac_y_copy = '0;
            pixels_due.delete();
        end else begin
            if (i_start && !i_busy) begin
                pixels_due.push_back(blend_pixel(i_tap_here, i_tap_right, i_tap_below,
                                                 i_tap_below_right, i_background,
                                                 frac_x_copy, frac_y_copy));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    RegFracX: frac_x_copy = i_cfg_data;
                    RegFracY: frac_y_copy = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid) begin
                results_seen++;
                if (pixels_due.size() == 0) begin
                    note_mismatch($sformatf("result %0d blended=%08h with no request waiting",
                                            results_seen, i_blended));
                end else begin
                    want = pixels_due.pop_front();
                    if (want !== i_blended) begin
                        note_mismatch($sformatf("result %0d blended expected %08h got %08h",
                                                results_seen, want, i_blended));
                    end
                end
            end
        end
        pending_count = pixels_due.size();
    end

endmodule

>>> bench/testbench.sv
// Top of the bilinear sprite blend bench: clock, reset, register writes and request stimulus.
// It depends on bsab_pkg, the block bilinear_sprite_alpha_blend_top and blend_checker.
`timescale 1ns / 1ps

module testbench;
    import bsab_pkg::*;

    localparam int RandomItems = 850;
    localparam int Phases      = 10;
    localparam int DrainCycles = 10;
    localparam int CycleLimit  = 200000;

    // Indexes beyond the register file; writes there must change nothing.
    localparam logic [CfgIdxW-1:0] RegSpareA = 2'd2;
    localparam logic [CfgIdxW-1:0] RegSpareB = 2'd3;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [31:0]        i_tap_here;
    logic [31:0]        i_tap_right;
    logic [31:0]        i_tap_below;
    logic [31:0]        i_tap_below_right;
    logic [31:0]        i_background;
    logic               o_valid;
    logic [31:0]        o_blended;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CfgIdxW-1:0] i_cfg_index;
    logic [7:0]         i_cfg_data;

    int          fail_count;
    int          pending;
    int          cycle_count;
    int unsigned sender_idle_pct;

    bilinear_sprite_alpha_blend_top uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_tap_here        (i_tap_here),
        .i_tap_right       (i_tap_right),
        .i_tap_below       (i_tap_below),
        .i_tap_below_right (i_tap_below_right),
        .i_background      (i_background),
        .o_valid           (o_valid),
        .o_blended         (o_blended),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    blend_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_tap_here        (i_tap_here),
        .i_tap_right       (i_tap_right),
        .i_tap_below       (i_tap_below),
        .i_tap_below_right (i_tap_below_right),
        .i_background      (i_background),
        .i_valid           (o_valid),
        .i_blended         (o_blended),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // 50 MHz clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog against a hung handshake or missing results.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    // One register write; the channel drops valid on the following falling edge.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_fractions(input logic [7:0] fx, input logic [7:0] fy);
        write_reg(RegFracX, fx);
        write_reg(RegFracY, fy);
    endtask

    // Present one request, with random idle cycles ahead of it, and wait for it to be taken.
    task automatic send_item(input logic [31:0] here, input logic [31:0] right,
                             input logic [31:0] below, input logic [31:0] below_right,
                             input logic [31:0] bg);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        start             <= 1'b1;
        i_tap_here        <= here;
        i_tap_right       <= right;
        i_tap_below       <= below;
        i_tap_below_right <= below_right;
        i_background      <= bg;
        do @(posedge i_clk); while (busy);
    endtask

    // Stop requests and let every predicted result come out before touching registers.
    task automatic wait_drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    // Texel with alpha often pinned to opaque or transparent.
    function automatic logic [31:0] rand_texel();
        logic [31:0] px;
        px = $urandom();
        case ($urandom_range(3))
            0: px[31:24] = 8'hFF;
            1: px[31:24] = 8'h00;
            default: ;
        endcase
        return px;
    endfunction

    function automatic logic [7:0] pick_fraction();
        case ($urandom_range(3))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    initial begin
        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_tap_here        = '0;
        i_tap_right       = '0;
        i_tap_below       = '0;
        i_tap_below_right = '0;
        i_background      = '0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = RegFracX;
        i_cfg_data        = '0;
        sender_idle_pct   = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset fractions: only the below-right tap carries weight.
        send_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 32'hFF10_2030, 32'h8080_8080);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h1234_5678);
        send_item(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
        wait_drain();

        // Writes to indexes past the register file must leave the fractions alone.
        write_reg(RegSpareA, 8'hFF);
        write_reg(RegSpareB, 8'h80);
        send_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        wait_drain();

        // Full-scale fractions put nearly all weight on the current texel.
        set_fractions(8'd255, 8'd255);
        send_item(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_item(32'h7F00_FF00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_drain();

        set_fractions(8'd255, 8'd0);
        send_item(32'h0000_0000, 32'h0000_0000, 32'hFFC0_FFEE, 32'h0000_0000, 32'h0102_0304);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        wait_drain();

        set_fractions(8'd0, 8'd255);
        send_item(32'h0000_0000, 32'hFF00_FF00, 32'h0000_0000, 32'h0000_0000, 32'h00FF_00FF);
        send_item(32'h0000_0000, 32'h80FF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        wait_drain();

        // Even split across all four taps.
        set_fractions(8'd128, 8'd128);
        send_item(32'hFF00_00FF, 32'hFF00_FF00, 32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(32'h00FF_FFFF, 32'h40FF_FFFF, 32'h80FF_FFFF, 32'hFFFF_FFFF, 32'hAAAA_AAAA);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_drain();

        set_fractions(8'd1, 8'd254);
        send_item(32'hC3A5_5A3C, 32'hE10F_F01E, 32'h9966_6699, 32'hFEDC_BA98, 32'h0123_4567);
        wait_drain();

        // Random phases: new fractions each time, cycling the sender idle rate.
        for (int p = 0; p < Phases; p++) begin
            case (p % 3)
                0: sender_idle_pct = 0;
                1: sender_idle_pct = 60;
                default: sender_idle_pct = 23;
            endcase
            if ($urandom_range(3) == 0) begin
                write_reg($urandom_range(1) ? RegSpareA : RegSpareB, 8'($urandom()));
            end
            set_fractions(pick_fraction(), pick_fraction());
            for (int n = 0; n < RandomItems / Phases; n++) begin
                send_item(rand_texel(), rand_texel(), rand_texel(), rand_texel(), $urandom());
            end
            wait_drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
design/bsab_pkg.sv
design/bsab_filter.sv
design/bilinear_sprite_alpha_blend_top.sv
bench/blend_checker.sv
bench/testbench.sv
